/* rtl/core/ssc_pkg.sv */
// Shared constants for the stack-sortable sequence check block.
`default_nettype none
package ssc_pkg;

    localparam int CAR_W            = 11;
    localparam int MAX_CARS_DEFAULT = 1024;

endpackage
`default_nettype wire

/* rtl/core/ssc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/stack_sortable_sequence_check_unit.sv */
// Top level of the stack-sortable sequence check: sequencer, stack state and RAM.
//
// Usage: item numbers enter one beat at a time on the s_ channel (s_car_number,
// s_last_car). The block decides whether the sequence can leave in order
// 1,2,3,... through one holding stack. The stack lives in a RAM of MAX_CARS
// entries; its top is kept in a register.
// Only the beat marked s_last_car produces a result beat on the m_ channel,
// m_can_order = 1 when the sequence sorts; all state is then cleared.
// Flow: a beat that is pushed, ignored or fails is handled in ST_IDLE. A beat that
// goes straight out passes through ST_DRAIN, and each stack entry popped after
// it takes a RAM read in ST_LOAD to refill the top register, except for the pop
// that empties the stack. A last beat then passes through ST_FINISH to load the
// result register. s_ready is low while a beat is being worked on.
// The result register holds m_can_order until m_ready; the next sequence may
// start meanwhile, and only the next verdict waits for the register to free.
// Reset (aresetn low, synchronous) empties the stack, clears the last number
// sent and the failure flag, and drops m_valid. No clearing pass is needed.
`default_nettype none
module stack_sortable_sequence_check_unit #(
    parameter int MAX_CARS = ssc_pkg::MAX_CARS_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ssc_pkg::CAR_W-1:0] s_car_number,
    input  wire logic                      s_last_car,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_can_order
);

    localparam int CW      = ssc_pkg::CAR_W;
    localparam int AW      = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int DEPTH_W = $clog2(MAX_CARS + 1);
    localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(MAX_CARS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_LOAD,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CW-1:0]     last_reg, last_next;
    logic              failed_reg, failed_next;
    logic              final_reg, final_next;
    logic [CW-1:0]     top_reg, top_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_can_reg, m_can_next;

    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     rd_data;
    logic [DEPTH_W-1:0] depth_m2;
    logic [CW:0]       last_inc;
    logic              in_match;
    logic              top_match;
    logic              push_ok;
    logic              accept;

    assign accept    = s_valid && s_ready;
    assign last_inc  = {1'b0, last_reg} + {{CW{1'b0}}, 1'b1};
    assign in_match  = ({1'b0, s_car_number} == last_inc);
    assign top_match = (depth_reg != '0) && ({1'b0, top_reg} == last_inc);
    assign push_ok   = (depth_reg == '0) || (top_reg > s_car_number);
    assign depth_m2  = depth_reg - DEPTH_W'(2);
    assign wr_addr   = depth_reg[AW-1:0];
    assign rd_addr   = depth_m2[AW-1:0];

    ssc_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_CARS)
    ) u_stack_ram (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_car_number),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        last_next    = last_reg;
        failed_next  = failed_reg;
        final_next   = final_reg;
        top_next     = top_reg;
        m_valid_next = m_valid_reg;
        m_can_next   = m_can_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    final_next = s_last_car;
                    state_next = s_last_car ? ST_FINISH : ST_IDLE;
                    if (!failed_reg) begin
                        if (in_match) begin
                            last_next  = s_car_number;
                            state_next = ST_DRAIN;
                        end else if (push_ok && depth_reg != FULL) begin
                            wr_en      = 1'b1;
                            top_next   = s_car_number;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (top_match) begin
                    last_next  = top_reg;
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (depth_reg > DEPTH_W'(1)) begin
                        rd_en      = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    state_next = final_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_LOAD: begin
                top_next   = rd_data;
                state_next = ST_DRAIN;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_can_next   = !failed_reg && (depth_reg == '0);
                    depth_next   = '0;
                    last_next    = '0;
                    failed_next  = 1'b0;
                    final_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            last_reg    <= '0;
            failed_reg  <= 1'b0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            last_reg    <= last_next;
            failed_reg  <= failed_next;
            final_reg   <= final_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg   <= top_next;
        m_can_reg <= m_can_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_can_order = m_can_reg;

endmodule
`default_nettype wire

/* rtl/core/ssc_checker.sv */
// Port-level checker for the stack-sortable sequence check block, with its bind.
`default_nettype none
module ssc_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic [ssc_pkg::CAR_W-1:0] s_car_number,
    input wire logic                      s_last_car,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_can_order
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_can_order))
        else $error("result beat changed while stalled");

    a_reset_drops_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_last_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_car |=> !s_ready)
        else $error("input accepted right after a last beat");

    a_no_result_on_middle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_car
        |=> !$rose(m_valid))
        else $error("result beat after a non-final item");

    a_result_not_while_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result loaded while input side idle");

endmodule

bind stack_sortable_sequence_check_unit ssc_checker u_ssc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_car_number(s_car_number),
    .s_last_car  (s_last_car),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_can_order (m_can_order)
);
`default_nettype wire

/* test/stack_sort_checker.sv */
// Beat monitor, stack-sort verdict predictor and scoreboard for the sequence check unit.
`timescale 1ns / 100ps
module stack_sort_checker (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic [ssc_pkg::CAR_W-1:0] s_car_number,
    input  wire logic                      s_last_car,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic                      m_can_order,
    output int                             mismatches,
    output int                             verdicts_pending,
    output int                             verdicts_checked
);

    logic [ssc_pkg::CAR_W-1:0] held_cars [ssc_pkg::MAX_CARS_DEFAULT];
    int               held_count;
    int               last_out;
    bit               order_broken;
    bit               expected_verdicts [$];
    bit               want_order;
    int               err_count;
    int               checked_count;

    assign mismatches       = err_count;
    assign verdicts_checked = checked_count;

    initial begin
        err_count     = 0;
        checked_count = 0;
        held_count    = 0;
        last_out      = 0;
        order_broken  = 1'b0;
    end

    task automatic absorb_car(input logic [ssc_pkg::CAR_W-1:0] car);
        if (order_broken) return;
        if (int'(car) == last_out + 1) begin
            last_out = int'(car);
            while (held_count > 0 && int'(held_cars[held_count-1]) == last_out + 1) begin
                last_out = int'(held_cars[held_count-1]);
                held_count--;
            end
        end else if (held_count == 0 || held_cars[held_count-1] > car) begin
            if (held_count >= ssc_pkg::MAX_CARS_DEFAULT) begin
                order_broken = 1'b1;
            end else begin
                held_cars[held_count] = car;
                held_count++;
            end
        end else begin
            order_broken = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count   = 0;
            last_out     = 0;
            order_broken = 1'b0;
            expected_verdicts.delete();
            verdicts_pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_car(s_car_number);
                if (s_last_car) begin
                    expected_verdicts.push_back(!order_broken && held_count == 0);
                    held_count   = 0;
                    last_out     = 0;
                    order_broken = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    if (err_count < 10)
                        $display("[%0t] unexpected verdict beat %b, none pending",
                                 $realtime, m_can_order);
                    err_count++;
                end else begin
                    want_order = expected_verdicts.pop_front();
                    if (m_can_order !== want_order) begin
                        if (err_count < 10)
                            $display("[%0t] can_order mismatch: expected %b, got %b",
                                     $realtime, want_order, m_can_order);
                        err_count++;
                    end
                    checked_count++;
                end
            end
            verdicts_pending <= expected_verdicts.size();
        end
    end

endmodule

/* test/tb_stack_sortable_sequence_check_unit.sv */
// Top of the sequence check testbench: clock, reset, beat stimulus and final verdict.
`timescale 1ns / 100ps
module tb_stack_sortable_sequence_check_unit;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        FLAW_NONE,
        FLAW_SWAP,
        FLAW_STRAY,
        FLAW_DROP,
        FLAW_DUP
    } run_flaw_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [ssc_pkg::CAR_W-1:0] s_car_number = '0;
    logic             s_last_car   = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic             m_can_order;

    int mismatches;
    int verdicts_pending;
    int verdicts_checked;
    int cycle_count = 0;
    int burst_left  = 0;
    int beats_sent  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    stack_sortable_sequence_check_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_car_number(s_car_number),
        .s_last_car  (s_last_car),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_can_order (m_can_order)
    );

    stack_sort_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_car_number    (s_car_number),
        .s_last_car      (s_last_car),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_can_order     (m_can_order),
        .mismatches      (mismatches),
        .verdicts_pending(verdicts_pending),
        .verdicts_checked(verdicts_checked)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     verdicts_pending);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (rx_left % 4 == 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_beat(input int car, input bit last);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
        s_valid      <= 1'b1;
        s_car_number <= car[ssc_pkg::CAR_W-1:0];
        s_last_car   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
    endtask

    // Build a sortable run from a random push/pop order, then optionally damage it.
    task automatic send_sorted_run(input int n, input run_flaw_t flaw);
        int order [$];
        int open_slots [$];
        int pushes;
        int next_val;
        int i;
        int j;
        int t;
        for (i = 0; i < n; i++) order.push_back(0);
        pushes   = 0;
        next_val = 1;
        while (pushes < n || open_slots.size() > 0) begin
            if (pushes < n && (open_slots.size() == 0 || $urandom_range(0, 1) == 1)) begin
                open_slots.push_back(pushes);
                pushes++;
            end else begin
                order[open_slots.pop_back()] = next_val;
                next_val++;
            end
        end
        i = $urandom_range(0, n - 1);
        j = $urandom_range(0, n - 1);
        case (flaw)
            FLAW_SWAP: begin
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            FLAW_STRAY: order[i] = $urandom_range(0, 2047);
            FLAW_DROP: if (n > 1) order.delete(i);
            FLAW_DUP: order.insert(i, order[i]);
            default: ;
        endcase
        for (i = 0; i < order.size(); i++) send_beat(order[i], i == order.size() - 1);
    endtask

    initial begin
        int car;
        int kind;
        int n;
        int len;
        int i;
        int runs;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-beat runs at the field extremes and at 1, 1024 and 1025
        send_beat(1, 1'b1);
        send_beat(0, 1'b1);
        send_beat(2047, 1'b1);
        send_beat(1024, 1'b1);
        send_beat(1025, 1'b1);
        // a sortable drain, a 231 pattern, a repeat, a gap, a sortable reversal, a zero
        send_beat(3, 1'b0);
        send_beat(1, 1'b0);
        send_beat(2, 1'b1);
        send_beat(2, 1'b0);
        send_beat(3, 1'b0);
        send_beat(1, 1'b1);
        send_beat(1, 1'b0);
        send_beat(1, 1'b1);
        send_beat(1, 1'b0);
        send_beat(3, 1'b1);
        send_beat(2, 1'b0);
        send_beat(1, 1'b1);
        send_beat(0, 1'b0);
        send_beat(1, 1'b1);
        wait_for_verdicts();

        runs = 0;
        while (beats_sent < 580) begin
            kind = $urandom_range(0, 9);
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
            if (kind < 6) begin
                send_sorted_run(n, FLAW_NONE);
            end else if (kind < 8) begin
                send_sorted_run(n, run_flaw_t'($urandom_range(FLAW_SWAP, FLAW_DUP)));
            end else begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    car = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 12);
                    send_beat(car, (i == len - 1) || ($urandom_range(0, 15) == 0));
                end
            end
            runs++;
            if (runs % 25 == 0) wait_for_verdicts();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("%0d beats sent, %0d verdicts checked, %0d mismatches", beats_sent,
                 verdicts_checked, mismatches);
        $display("runs: edge numbers, sortable, damaged and noisy, with stalls on both sides");
        if (mismatches == 0 && verdicts_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ssc_pkg.sv
rtl/core/ssc_ram.sv
rtl/core/stack_sortable_sequence_check_unit.sv
rtl/core/ssc_checker.sv
test/stack_sort_checker.sv
test/tb_stack_sortable_sequence_check_unit.sv
